@@ rtl/mhv_pkg.sv @@
// Shared types and constants for the metadata header validator.
// Holds the status codes, the queue item layout and the queue status group.
// No dependencies.
`default_nettype none

package mhv_pkg;

  // Byte address width of the configuration port.
  localparam int unsigned ADDR_W      = 3;
  localparam int unsigned DATA_W      = 32;
  localparam int unsigned LEN_W       = 33;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0]  COLON_BYTE  = 8'h3A;
  localparam logic [31:0] BIN_SUFFIX  = 32'h2D62696E;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_KEY_EMPTY  = 3'd1,
    ST_KEY_LONG   = 3'd2,
    ST_KEY_COLON  = 3'd3,
    ST_KEY_BYTE   = 3'd4,
    ST_VALUE_BYTE = 3'd5
  } status_e;

  // One classified request, as held in the queue.
  typedef struct packed {
    logic       is_value;
    logic       has_byte;
    logic       last;
    logic [7:0] data_byte;
    logic       key_ok;
    logic       is_colon;
    logic       value_ok;
  } mhv_item_t;

  typedef struct packed {
    logic              full;
    logic              valid;
    logic [QCNT_W-1:0] count;
  } mhv_qstat_t;

endpackage

`default_nettype wire

@@ rtl/metadata_header_validator.sv @@
// Metadata header validator.
// Input channel: one request per key or value byte (kind_i 0 key, 1 value),
// has_byte_i low marks an empty part, last_i ends the key or the value.
// Requests of the wrong kind for the current part are dropped silently.
// Output channel: one status per header, given after its final value request;
// is_binary_o flags a valid key ending in "-bin", whose value goes unchecked.
// Throughput: one request per cycle while in_stall_o is low. A request passes
// through the front end into a two-entry queue and on to the back end, whose
// output register holds the status of each header.
// A stalled output holds its status; the back end keeps consuming key and
// value bytes until it meets the next header end, then the queue fills and
// in_stall_o rises.
// Register at byte address 0: max_key_length (32 bits), reset 0xFFFFFFFF.
// Write it only while no header is in flight.
// Reset clears the phase, the queue and all header state but the status and
// binary-flag registers; the block is ready for a key once reset is released.
// Depends on mhv_pkg, mhv_front, mhv_queue and mhv_back.
`default_nettype none

module metadata_header_validator import mhv_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire logic              kind_i,
  input  wire logic [7:0]        data_byte_i,
  input  wire logic              has_byte_i,
  input  wire logic              last_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic [2:0]             status_o,
  output logic                   is_binary_o,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0]      prdata,
  output logic                   pready
);

  localparam logic [ADDR_W-3:0] REG_MAX_KEY_LEN = '0;

  logic [DATA_W-1:0] max_len_q;
  logic              cfg_wr;
  logic              reg_sel;
  mhv_qstat_t        q_stat;
  mhv_item_t         push_item;
  mhv_item_t         head_item;
  logic              push;
  logic              pop;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[ADDR_W-1:2] == REG_MAX_KEY_LEN);
  assign cfg_wr  = psel && penable && pwrite && pready && reg_sel;
  assign prdata  = reg_sel ? max_len_q : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= '1;
    end else if (cfg_wr) begin
      max_len_q <= pwdata;
    end
  end

  mhv_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .kind_i      (kind_i),
    .data_byte_i (data_byte_i),
    .has_byte_i  (has_byte_i),
    .last_i      (last_i),
    .q_stat_i    (q_stat),
    .push_o      (push),
    .item_o      (push_item)
  );

  mhv_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .item_i (push_item),
    .pop_i  (pop),
    .item_o (head_item),
    .stat_o (q_stat)
  );

  mhv_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_stat_i      (q_stat),
    .item_i        (head_item),
    .pop_o         (pop),
    .max_key_len_i (max_len_q),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .status_o      (status_o),
    .is_binary_o   (is_binary_o)
  );

`ifndef NO_ASSERTIONS
  a_bin_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_binary_o |-> status_o == ST_OK)
    else $error("binary flag with a failing status");

  a_end_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop && head_item.is_value && head_item.last |=> out_valid_o)
    else $error("header end consumed without a status");

  a_q_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_stat.count <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue count beyond depth");

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !q_stat.full)
    else $error("push into a full queue");
`endif

endmodule

`default_nettype wire

@@ rtl/mhv_front.sv @@
// Front end: takes requests, tracks key/value phase, classifies each byte.
// Depends on mhv_pkg.
`default_nettype none

module mhv_front import mhv_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic       kind_i,
  input  wire logic [7:0] data_byte_i,
  input  wire logic       has_byte_i,
  input  wire logic       last_i,
  input  wire mhv_qstat_t q_stat_i,
  output logic            push_o,
  output mhv_item_t       item_o
);

  logic phase_q, phase_d;
  logic accept;
  logic match;
  logic key_ok;

  assign in_stall_o = q_stat_i.full;
  assign accept     = in_valid_i && !q_stat_i.full;
  // Drop requests of the wrong part; empty non-final requests carry nothing.
  assign match      = accept && (kind_i == phase_q);
  assign push_o     = match && (has_byte_i || last_i);
  assign phase_d    = (match && last_i) ? ~phase_q : phase_q;

  always_comb begin
    key_ok = 1'b0;
    if ((data_byte_i == 8'h2D) || (data_byte_i == 8'h2E) || (data_byte_i == 8'h5F)) begin
      key_ok = 1'b1;
    end
    if ((data_byte_i >= 8'h30) && (data_byte_i <= 8'h39)) begin
      key_ok = 1'b1;
    end
    if ((data_byte_i >= 8'h61) && (data_byte_i <= 8'h7A)) begin
      key_ok = 1'b1;
    end
  end

  always_comb begin
    item_o.is_value  = phase_q;
    item_o.has_byte  = has_byte_i;
    item_o.last      = last_i;
    item_o.data_byte = data_byte_i;
    item_o.key_ok    = key_ok;
    item_o.is_colon  = (data_byte_i == COLON_BYTE);
    item_o.value_ok  = (data_byte_i >= 8'h20) && (data_byte_i <= 8'h7E);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
    end
  end

endmodule

`default_nettype wire

@@ rtl/mhv_queue.sv @@
// Short request queue between the front end and the back end.
// Depends on mhv_pkg.
`default_nettype none

module mhv_queue import mhv_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      push_i,
  input  wire mhv_item_t item_i,
  input  wire logic      pop_i,
  output mhv_item_t      item_o,
  output mhv_qstat_t     stat_o
);

  mhv_item_t         mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;

  function automatic logic [QPTR_W-1:0] ptr_next(input logic [QPTR_W-1:0] p);
    logic [QPTR_W-1:0] r;
    if (p == QPTR_W'(QUEUE_DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + QPTR_W'(1);
    end
    return r;
  endfunction

  assign wr_ptr_d = push_i ? ptr_next(wr_ptr_q) : wr_ptr_q;
  assign rd_ptr_d = pop_i  ? ptr_next(rd_ptr_q) : rd_ptr_q;

  always_comb begin
    unique case ({push_i, pop_i})
      2'b10:   cnt_d = cnt_q + QCNT_W'(1);
      2'b01:   cnt_d = cnt_q - QCNT_W'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  assign item_o       = mem_q[rd_ptr_q];
  assign stat_o.full  = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign stat_o.valid = (cnt_q != '0);
  assign stat_o.count = cnt_q;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

`default_nettype wire

@@ rtl/mhv_back.sv @@
// Back end: accumulates key and value checks and registers the header status.
// Depends on mhv_pkg.
`default_nettype none

module mhv_back import mhv_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire mhv_qstat_t        q_stat_i,
  input  wire mhv_item_t         item_i,
  output logic                   pop_o,
  input  wire logic [DATA_W-1:0] max_key_len_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic [2:0]             status_o,
  output logic                   is_binary_o
);

  logic [LEN_W-1:0] key_len_q, key_len_d;
  logic [31:0]      key_tail_q, key_tail_d;
  status_e          key_st_q, key_st_d;
  logic             value_bad_q, value_bad_d;
  logic             out_valid_q, out_valid_d;
  status_e          status_q, status_d;
  logic             bin_q, bin_d;
  logic             ends_header;
  logic             slot_free;

  assign ends_header = item_i.is_value && item_i.last;
  assign slot_free   = !out_valid_q || !out_stall_i;
  // Hold a header end while the previous status still waits.
  assign pop_o       = q_stat_i.valid && (!ends_header || slot_free);

  always_comb begin
    key_len_d   = key_len_q;
    key_tail_d  = key_tail_q;
    key_st_d    = key_st_q;
    value_bad_d = value_bad_q;
    status_d    = status_q;
    bin_d       = bin_q;
    out_valid_d = out_valid_q && out_stall_i;

    if (pop_o) begin
      if (!item_i.is_value) begin
        if (item_i.has_byte) begin
          if (key_len_q == '0) begin
            if (item_i.is_colon) begin
              key_st_d = ST_KEY_COLON;
            end else if (item_i.key_ok) begin
              key_st_d = ST_OK;
            end else begin
              key_st_d = ST_KEY_BYTE;
            end
          end else if ((key_st_q == ST_OK) && !item_i.key_ok) begin
            key_st_d = ST_KEY_BYTE;
          end
          key_tail_d = {key_tail_q[23:0], item_i.data_byte};
          if (key_len_q != '1) begin
            key_len_d = key_len_q + LEN_W'(1);
          end
        end
        if (item_i.last) begin
          if (key_len_d == '0) begin
            key_st_d = ST_KEY_EMPTY;
          end else if (key_len_d > {1'b0, max_key_len_i}) begin
            key_st_d = ST_KEY_LONG;
          end
        end
      end else begin
        if (item_i.has_byte && !item_i.value_ok) begin
          value_bad_d = 1'b1;
        end
        if (item_i.last) begin
          out_valid_d = 1'b1;
          bin_d       = 1'b0;
          if (key_st_q != ST_OK) begin
            status_d = key_st_q;
          end else if (key_tail_q == BIN_SUFFIX) begin
            status_d = ST_OK;
            bin_d    = 1'b1;
          end else if (value_bad_d) begin
            status_d = ST_VALUE_BYTE;
          end else begin
            status_d = ST_OK;
          end
          // Clear for the next header.
          key_len_d   = '0;
          key_tail_d  = '0;
          key_st_d    = ST_OK;
          value_bad_d = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_len_q   <= '0;
      key_tail_q  <= '0;
      key_st_q    <= ST_OK;
      value_bad_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      key_len_q   <= key_len_d;
      key_tail_q  <= key_tail_d;
      key_st_q    <= key_st_d;
      value_bad_q <= value_bad_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    bin_q    <= bin_d;
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign is_binary_o = bin_q;

endmodule

`default_nettype wire
